// ===== src/assert_macros.svh =====
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// implication checked every clock outside reset
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
// next-cycle implication checked outside reset
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`endif

// ===== src/sck_pkg.sv =====
// package with sha-256 constants, round constant function and shared command types
`default_nettype none
package sck_pkg;
   localparam int unsigned RoundCount = 64;
   localparam logic [2:0] CsrKey0 = 3'd0;
   localparam logic [2:0] CsrKey1 = 3'd1;
   localparam logic [2:0] CsrKey2 = 3'd2;
   localparam logic [2:0] CsrKey3 = 3'd3;
   localparam logic [2:0] CsrKeyPresent = 3'd4;

   typedef struct packed {
      logic load_key;
      logic start_hash;
      logic hash_step;
      logic hash_done;
      logic take_byte;
      logic emit;
   } ctrl_cmd_type;

   typedef struct packed {
      logic pos_zero;
      logic last_round;
   } ctrl_status_type;

   function automatic logic [31:0] round_k(input logic [5:0] idx);
      logic [31:0] k [64];
      k = '{
         32'h428a2f98,32'h71374491,32'hb5c0fbcf,32'he9b5dba5,32'h3956c25b,32'h59f111f1,
         32'h923f82a4,32'hab1c5ed5,32'hd807aa98,32'h12835b01,32'h243185be,32'h550c7dc3,
         32'h72be5d74,32'h80deb1fe,32'h9bdc06a7,32'hc19bf174,32'he49b69c1,32'hefbe4786,
         32'h0fc19dc6,32'h240ca1cc,32'h2de92c6f,32'h4a7484aa,32'h5cb0a9dc,32'h76f988da,
         32'h983e5152,32'ha831c66d,32'hb00327c8,32'hbf597fc7,32'hc6e00bf3,32'hd5a79147,
         32'h06ca6351,32'h14292967,32'h27b70a85,32'h2e1b2138,32'h4d2c6dfc,32'h53380d13,
         32'h650a7354,32'h766a0abb,32'h81c2c92e,32'h92722c85,32'ha2bfe8a1,32'ha81a664b,
         32'hc24b8b70,32'hc76c51a3,32'hd192e819,32'hd6990624,32'hf40e3585,32'h106aa070,
         32'h19a4c116,32'h1e376c08,32'h2748774c,32'h34b0bcb5,32'h391c0cb3,32'h4ed8aa4a,
         32'h5b9cca4f,32'h682e6ff3,32'h748f82ee,32'h78a5636f,32'h84c87814,32'h8cc70208,
         32'h90befffa,32'ha4506ceb,32'hbef9a3f7,32'hc67178f2};
      return k[idx];
   endfunction

   localparam logic [255:0] InitH = {32'h6a09e667,32'hbb67ae85,32'h3c6ef372,32'ha54ff53a,
                                     32'h510e527f,32'h9b05688c,32'h1f83d9ab,32'h5be0cd19};
endpackage
`default_nettype wire

// ===== src/sck_datapath.sv =====
// datapath: key registers, chain block, iterative sha-256 round unit and output register
`default_nettype none
module sck_datapath (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 csr_valid,
   input  wire logic [2:0]           csr_index,
   input  wire logic [63:0]          csr_data,
   input  wire sck_pkg::ctrl_cmd_type cmd,
   output sck_pkg::ctrl_status_type  status,
   output logic                      key_present,
   input  wire logic [7:0]           in_byte,
   input  wire logic                 in_last,
   output logic [7:0]                out_byte,
   output logic                      out_last
);
   logic [255:0] key_ff;
   logic         key_present_ff;
   logic [255:0] chain_ff;
   logic [255:0] state_ff;
   logic [511:0] sched_ff;
   logic [5:0]   round_ff;
   logic [4:0]   pos_ff;
   logic [7:0]   out_byte_ff;
   logic         out_last_ff;

   function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
      return (x >> n) | (x << (32 - n));
   endfunction

   logic [31:0] a, b, c, d, e, f, g, h, t1, t2, w0, s0, s1, w_new;
   logic [255:0] next_state;
   logic [7:0]  ks;
   always_comb begin
      {a, b, c, d, e, f, g, h} = state_ff;
      w0 = sched_ff[511:480];
      t1 = h + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25)) + ((e & f) ^ (~e & g))
           + sck_pkg::round_k(round_ff) + w0;
      t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
      next_state = {t1 + t2, a, b, c, d + t1, e, f, g};
      s0 = rotr(sched_ff[479:448], 7) ^ rotr(sched_ff[479:448], 18)
           ^ (sched_ff[479:448] >> 3);
      s1 = rotr(sched_ff[63:32], 17) ^ rotr(sched_ff[63:32], 19) ^ (sched_ff[63:32] >> 10);
      w_new = w0 + s0 + sched_ff[223:192] + s1;
      ks = chain_ff[8'd255 - {pos_ff, 3'b000} -: 8];
   end

   logic [255:0] digest;
   always_comb begin
      for (int i = 0; i < 8; i++) begin
         digest[i*32 +: 32] = next_state[i*32 +: 32] + sck_pkg::InitH[i*32 +: 32];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_ff <= '0;
         key_present_ff <= 1'b0;
         round_ff <= '0;
         pos_ff <= '0;
      end else begin
         if (csr_valid) begin
            unique case (csr_index)
               sck_pkg::CsrKey0: key_ff[255:192] <= csr_data;
               sck_pkg::CsrKey1: key_ff[191:128] <= csr_data;
               sck_pkg::CsrKey2: key_ff[127:64] <= csr_data;
               sck_pkg::CsrKey3: key_ff[63:0] <= csr_data;
               sck_pkg::CsrKeyPresent: key_present_ff <= csr_data[0];
               default: ;
            endcase
         end
         if (cmd.load_key) begin
            chain_ff <= key_ff;
            pos_ff <= '0;
         end
         if (cmd.start_hash) begin
            state_ff <= sck_pkg::InitH;
            sched_ff <= {cmd.load_key ? key_ff : chain_ff, 32'h80000000, 192'd0, 32'd256};
            round_ff <= '0;
         end
         if (cmd.hash_step) begin
            state_ff <= next_state;
            sched_ff <= {sched_ff[479:0], w_new};
            round_ff <= round_ff + 6'd1;
         end
         if (cmd.hash_done) chain_ff <= digest;
         if (cmd.take_byte) begin
            out_byte_ff <= in_byte ^ ks;
            out_last_ff <= in_last;
            pos_ff <= in_last ? 5'd0 : pos_ff + 5'd1;
         end
      end
   end

   assign status.pos_zero = (pos_ff == 5'd0);
   assign status.last_round = (round_ff == 6'(sck_pkg::RoundCount - 1));
   assign key_present = key_present_ff;
   assign out_byte = out_byte_ff;
   assign out_last = out_last_ff;
endmodule
`default_nettype wire

// ===== src/sck_control.sv =====
// controller state machine: message start, chain advance and byte handshake
`default_nettype none
module sck_control (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_tvalid,
   output logic                        req_tready,
   input  wire logic                   req_last,
   output logic                        rsp_tvalid,
   input  wire logic                   rsp_tready,
   input  wire logic                   key_present,
   input  wire sck_pkg::ctrl_status_type status,
   output sck_pkg::ctrl_cmd_type       cmd
);
   typedef enum logic [1:0] {IDLE, HASH, READY} state_type;
   state_type state_ff;
   logic in_msg_ff, rsp_valid_ff;

   always_comb begin
      cmd = '0;
      req_tready = (state_ff == READY) && (!rsp_valid_ff || rsp_tready);
      unique case (state_ff)
         IDLE:  begin
            cmd.load_key = req_tvalid && key_present && !in_msg_ff;
            cmd.start_hash = req_tvalid && key_present && (!in_msg_ff || status.pos_zero);
         end
         HASH:  begin
            cmd.hash_step = 1'b1;
            cmd.hash_done = status.last_round;
         end
         READY: cmd.take_byte = req_tvalid && req_tready && key_present;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= IDLE;
         in_msg_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= cmd.take_byte || (rsp_valid_ff && !rsp_tready);
         unique case (state_ff)
            IDLE: if (req_tvalid) begin
               if (!key_present) state_ff <= READY;
               else if (cmd.start_hash) begin
                  state_ff <= HASH;
                  in_msg_ff <= 1'b1;
               end else state_ff <= READY;
            end
            HASH: if (status.last_round) state_ff <= READY;
            READY: if (req_tvalid && req_tready) begin
               state_ff <= IDLE;
               if (key_present && req_last) in_msg_ff <= 1'b0;
            end
            default: state_ff <= IDLE;
         endcase
      end
   end
   assign rsp_tvalid = rsp_valid_ff;
endmodule
`default_nettype wire

// ===== src/sha256_chain_keystream_xor.sv =====
// top level of the sha-256 hash-chain keystream xor block
// channel | direction | payload
// req     | in        | tdata = data_byte, tlast = last
// rsp     | out       | tdata = out_byte, tlast = out_last
// csr     | in        | index 0-3 key words, 4 key_present
// a byte passes through the idle and ready states; the first byte of each 32-byte group
// also runs the iterative sha-256 compression in the hash state (one round a cycle)
// reset clears control and the key registers
// results sit in an output register; a waiting result holds off the next byte
// with key_present low bytes are accepted and dropped
`default_nettype none
module sha256_chain_keystream_xor (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata, // data_byte
   input  wire logic        req_tlast,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [7:0]       rsp_tdata, // out_byte
   output logic             rsp_tlast,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [2:0]  csr_index,
   input  wire logic [63:0] csr_data
);
   sck_pkg::ctrl_cmd_type    cmd;
   sck_pkg::ctrl_status_type status;
   logic key_present;

   assign csr_ready = 1'b1;

   sck_control u_control (
      .clock, .reset, .req_tvalid, .req_tready, .req_last(req_tlast),
      .rsp_tvalid, .rsp_tready, .key_present, .status, .cmd);

   sck_datapath u_datapath (
      .clock, .reset, .csr_valid, .csr_index, .csr_data, .cmd, .status, .key_present,
      .in_byte(req_tdata), .in_last(req_tlast), .out_byte(rsp_tdata), .out_last(rsp_tlast));
endmodule
`default_nettype wire

// ===== src/sck_checker.sv =====
// port checker bound to the top level
`include "assert_macros.svh"
`default_nettype none
module sck_checker (
   input wire logic clock,
   input wire logic reset,
   input wire logic req_tvalid,
   input wire logic req_tready,
   input wire logic rsp_tvalid,
   input wire logic rsp_tready,
   input wire logic [7:0] rsp_tdata
);
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid)
   `ASSERT_NEXT(a_data_hold, clock, reset, rsp_tvalid && !rsp_tready, $stable(rsp_tdata))
   `ASSERT_NEXT(a_no_back2back, clock, reset, req_tvalid && req_tready, !req_tready)
   `ASSERT_IMPLIES(a_no_overrun, clock, reset, rsp_tvalid && !rsp_tready, !req_tready)
endmodule
bind sha256_chain_keystream_xor sck_checker u_sck_checker (.*);
`default_nettype wire

// ===== test/tb_top.sv =====
// testbench for the sha-256 hash-chain keystream xor block
`timescale 1ns / 100ps
`default_nettype none
module tb_top;
   localparam int unsigned WatchdogLimit = 4000;
   localparam int unsigned DrainCycles = 120;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [7:0]  req_tdata;
   logic        req_tlast;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [7:0]  rsp_tdata;
   logic        rsp_tlast;
   logic        csr_valid;
   logic        csr_ready;
   logic [2:0]  csr_index;
   logic [63:0] csr_data;

   sha256_chain_keystream_xor dut (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata), // data_byte
      .req_tlast(req_tlast),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), // out_byte
      .rsp_tlast(rsp_tlast),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_data(csr_data)
   );

   localparam logic [31:0] RoundConst [64] = '{
      32'h428a2f98,32'h71374491,32'hb5c0fbcf,32'he9b5dba5,32'h3956c25b,32'h59f111f1,
      32'h923f82a4,32'hab1c5ed5,32'hd807aa98,32'h12835b01,32'h243185be,32'h550c7dc3,
      32'h72be5d74,32'h80deb1fe,32'h9bdc06a7,32'hc19bf174,32'he49b69c1,32'hefbe4786,
      32'h0fc19dc6,32'h240ca1cc,32'h2de92c6f,32'h4a7484aa,32'h5cb0a9dc,32'h76f988da,
      32'h983e5152,32'ha831c66d,32'hb00327c8,32'hbf597fc7,32'hc6e00bf3,32'hd5a79147,
      32'h06ca6351,32'h14292967,32'h27b70a85,32'h2e1b2138,32'h4d2c6dfc,32'h53380d13,
      32'h650a7354,32'h766a0abb,32'h81c2c92e,32'h92722c85,32'ha2bfe8a1,32'ha81a664b,
      32'hc24b8b70,32'hc76c51a3,32'hd192e819,32'hd6990624,32'hf40e3585,32'h106aa070,
      32'h19a4c116,32'h1e376c08,32'h2748774c,32'h34b0bcb5,32'h391c0cb3,32'h4ed8aa4a,
      32'h5b9cca4f,32'h682e6ff3,32'h748f82ee,32'h78a5636f,32'h84c87814,32'h8cc70208,
      32'h90befffa,32'ha4506ceb,32'hbef9a3f7,32'hc67178f2};
   localparam logic [31:0] StartHash [8] = '{
      32'h6a09e667,32'hbb67ae85,32'h3c6ef372,32'ha54ff53a,
      32'h510e527f,32'h9b05688c,32'h1f83d9ab,32'h5be0cd19};

   function automatic logic [31:0] ror(input logic [31:0] x, input int n);
      return (x >> n) | (x << (32 - n));
   endfunction

   // digest of a single padded 32-byte message
   function automatic logic [255:0] digest_of_block(input logic [255:0] blk);
      logic [31:0] w [64];
      logic [31:0] v [8];
      logic [31:0] t1, t2, s0, s1;
      logic [255:0] res;
      for (int i = 0; i < 8; i++) w[i] = blk[255 - 32 * i -: 32];
      w[8] = 32'h80000000;
      for (int i = 9; i < 15; i++) w[i] = 32'h0;
      w[15] = 32'd256;
      for (int i = 16; i < 64; i++) begin
         s0 = ror(w[i-15], 7) ^ ror(w[i-15], 18) ^ (w[i-15] >> 3);
         s1 = ror(w[i-2], 17) ^ ror(w[i-2], 19) ^ (w[i-2] >> 10);
         w[i] = w[i-16] + s0 + w[i-7] + s1;
      end
      for (int i = 0; i < 8; i++) v[i] = StartHash[i];
      for (int i = 0; i < 64; i++) begin
         t1 = v[7] + (ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25))
              + ((v[4] & v[5]) ^ (~v[4] & v[6])) + RoundConst[i] + w[i];
         t2 = (ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22))
              + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
         v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
         v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
      end
      for (int i = 0; i < 8; i++) res[255 - 32 * i -: 32] = v[i] + StartHash[i];
      return res;
   endfunction

   typedef struct packed {
      logic [7:0] data;
      logic       last;
   } cipher_byte_type;

   class keystream_scoreboard;
      logic [63:0]  key_words [4];
      logic         key_on;
      logic [255:0] chain;
      logic [4:0]   pos;
      logic         in_msg;
      cipher_byte_type expected_bytes [$];
      int           errors;

      function void clear();
         for (int i = 0; i < 4; i++) key_words[i] = '0;
         key_on = 1'b0;
         chain = '0;
         pos = '0;
         in_msg = 1'b0;
         expected_bytes.delete();
         errors = 0;
      endfunction

      function void write_reg(input logic [2:0] idx, input logic [63:0] val);
         case (idx)
            sck_pkg::CsrKey0: key_words[0] = val;
            sck_pkg::CsrKey1: key_words[1] = val;
            sck_pkg::CsrKey2: key_words[2] = val;
            sck_pkg::CsrKey3: key_words[3] = val;
            sck_pkg::CsrKeyPresent: key_on = val[0];
            default: ;
         endcase
      endfunction

      function void note_input(input logic [7:0] d, input logic l);
         cipher_byte_type e;
         if (!key_on) return;
         if (!in_msg) begin
            chain = {key_words[0], key_words[1], key_words[2], key_words[3]};
            pos = '0;
            in_msg = 1'b1;
         end
         if (pos == 0) chain = digest_of_block(chain);
         e.data = d ^ chain[255 - 8 * pos -: 8];
         e.last = l;
         expected_bytes.push_back(e);
         pos = pos + 1'b1;
         if (l) begin
            in_msg = 1'b0;
            pos = '0;
         end
      endfunction

      function void check_output(input logic [7:0] d, input logic l);
         cipher_byte_type e;
         if (expected_bytes.size() == 0) begin
            $display("%0t unexpected transaction: expected none, actual %h last %b",
                     $time, d, l);
            errors++;
            return;
         end
         e = expected_bytes.pop_front();
         if (d !== e.data) begin
            $display("%0t out_byte mismatch: expected %h, actual %h", $time, e.data, d);
            errors++;
         end
         if (l !== e.last) begin
            $display("%0t out_last mismatch: expected %b, actual %b", $time, e.last, l);
            errors++;
         end
      endfunction
   endclass

   keystream_scoreboard sb;
   int unsigned req_idle_pct;
   int unsigned rsp_idle_pct;
   int unsigned hold_requests;
   int unsigned hold_served;
   int unsigned hold_left;
   int unsigned quiet_cycles;
   int unsigned sent_bytes;

   always begin
      clock = 1'b1;
      #4;
      clock = 1'b0;
      #4;
   end

   // result side: check and random backpressure
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) sb.check_output(rsp_tdata, rsp_tlast);
         if (hold_served != hold_requests) begin
            hold_served = hold_requests;
            hold_left = 400;
         end
         if (hold_left != 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(99) >= rsp_idle_pct);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)
          || (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WatchdogLimit) begin
         $display("Test completed with failures");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic write_csr(input logic [2:0] idx, input logic [63:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      do @(posedge clock); while (!csr_ready);
      sb.write_reg(idx, val);
      csr_valid <= 1'b0;
   endtask

   task automatic load_key(input logic [63:0] k0, k1, k2, k3);
      write_csr(sck_pkg::CsrKey0, k0);
      write_csr(sck_pkg::CsrKey1, k1);
      write_csr(sck_pkg::CsrKey2, k2);
      write_csr(sck_pkg::CsrKey3, k3);
   endtask

   task automatic send_byte(input logic [7:0] d, input logic l);
      while ($urandom_range(99) < req_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= d;
      req_tlast <= l;
      do @(posedge clock); while (!req_tready);
      if (sb.key_on) sent_bytes++;
      sb.note_input(d, l);
   endtask

   task automatic wait_idle();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (sb.expected_bytes.size() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
   endtask

   task automatic send_message(input int unsigned len, input bit reconfig);
      int unsigned cut;
      cut = reconfig ? $urandom_range(len - 1) : len;
      for (int unsigned i = 0; i < len; i++) begin
         if (i == cut) begin
            // new key mid-message applies only from the next message
            wait_idle();
            write_csr(3'($urandom_range(3)), {$urandom, $urandom});
            if ($urandom_range(2) == 0) begin
               write_csr(sck_pkg::CsrKeyPresent, 64'd0);
               repeat ($urandom_range(1, 4))
                  send_byte(8'($urandom_range(255)), 1'($urandom_range(1)));
               wait_idle();
               write_csr(sck_pkg::CsrKeyPresent, 64'd1);
            end
         end
         send_byte(8'($urandom_range(255)), i == len - 1);
      end
   endtask

   task automatic random_phase(input int unsigned goal);
      int unsigned r, len;
      wait_idle();
      load_key({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
               {$urandom, $urandom});
      write_csr(sck_pkg::CsrKeyPresent, 64'd1);
      hold_requests++;
      goal = sent_bytes + goal;
      while (sent_bytes < goal) begin
         r = $urandom_range(99);
         len = (r < 88) ? $urandom_range(1, 70) : $urandom_range(71, 200);
         send_message(len, $urandom_range(9) == 0);
      end
   endtask

   initial begin
      sb = new();
      sb.clear();
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tlast = 1'b0;
      rsp_tready = 1'b0;
      csr_valid = 1'b0;
      csr_index = '0;
      csr_data = '0;
      req_idle_pct = 0;
      rsp_idle_pct = 0;
      hold_requests = 0;
      hold_served = 0;
      hold_left = 0;
      sent_bytes = 0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // no key: bytes are dropped
      send_byte(8'h00, 1'b0);
      send_byte(8'hff, 1'b1);
      wait_idle();

      // all-zero key, group boundary crossing
      load_key('0, '0, '0, '0);
      write_csr(sck_pkg::CsrKeyPresent, 64'd1);
      send_byte(8'h00, 1'b1);
      send_byte(8'hff, 1'b1);
      for (int i = 0; i < 34; i++) send_byte((i & 1) ? 8'h55 : 8'haa, i == 33);
      wait_idle();

      // all-ones key, changed mid-message
      load_key('1, '1, '1, '1);
      for (int i = 0; i < 5; i++) send_byte(8'hff, 1'b0);
      wait_idle();
      load_key(64'h0123456789abcdef, '0, '1, 64'h8000000000000001);
      for (int i = 0; i < 4; i++) send_byte(8'h0f << i, i == 3);
      send_byte(8'h80, 1'b1);

      req_idle_pct = 22;
      rsp_idle_pct = 46;
      random_phase(530);
      req_idle_pct = 46;
      rsp_idle_pct = 22;
      random_phase(530);
      req_idle_pct = 0;
      rsp_idle_pct = 0;
      random_phase(530);
      wait_idle();
      write_csr(sck_pkg::CsrKeyPresent, 64'd0);

      wait_idle();
      if (sb.errors == 0 && sb.expected_bytes.size() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end
endmodule
`default_nettype wire

// ===== filelist.f =====
+incdir+src
src/sck_pkg.sv
src/sck_datapath.sv
src/sck_control.sv
src/sha256_chain_keystream_xor.sv
src/sck_checker.sv
test/tb_top.sv
